// ===== hw/rtl/smpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared codes and control types for the stable min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    // operation codes carried on i_func
    localparam logic FUNC_JOIN  = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    localparam int unsigned OUT_TAG_BITS = 16;
    localparam int unsigned PRI_BITS     = 32;

    // broadcast to every cell of the row
    typedef struct packed {
        logic shift_in;   // join that is taken: open a gap, drop the new word in
        logic shift_out;  // leave that is taken: every cell takes its right neighbour
    } t_cell_ctl;

endpackage

// ===== hw/rtl/smpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds a tag and a priority, decides locally
// whether a new word belongs in front of it, and shifts left or right.
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int unsigned TAG_BITS = 16
) (
    input  logic                             i_clk,
    input  smpq_pkg::t_cell_ctl              i_ctl,
    input  logic                             i_valid,
    input  logic [TAG_BITS-1:0]              i_new_tag,
    input  logic signed [smpq_pkg::PRI_BITS-1:0] i_new_pri,
    input  logic                             i_prev_before,
    input  logic [TAG_BITS-1:0]              i_prev_tag,
    input  logic signed [smpq_pkg::PRI_BITS-1:0] i_prev_pri,
    input  logic [TAG_BITS-1:0]              i_next_tag,
    input  logic signed [smpq_pkg::PRI_BITS-1:0] i_next_pri,
    output logic [TAG_BITS-1:0]              o_tag,
    output logic signed [smpq_pkg::PRI_BITS-1:0] o_pri,
    output logic                             o_before
);
    import smpq_pkg::*;

    logic [TAG_BITS-1:0]        r_tag, n_tag;
    logic signed [PRI_BITS-1:0] r_pri, n_pri;

    // strict less: an equal priority queues behind the older word
    assign o_before = !i_valid || (i_new_pri < r_pri);

    always_comb begin
        n_tag = r_tag;
        n_pri = r_pri;
        if (i_ctl.shift_out) begin
            n_tag = i_next_tag;
            n_pri = i_next_pri;
        end else if (i_ctl.shift_in && o_before) begin
            if (i_prev_before) begin
                n_tag = i_prev_tag;
                n_pri = i_prev_pri;
            end else begin
                n_tag = i_new_tag;
                n_pri = i_new_pri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_pri <= n_pri;
    end

    assign o_tag = r_tag;
    assign o_pri = r_pri;

endmodule

// ===== hw/rtl/stable_min_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded min-priority queue with first-in tie break, built as a sorted row
// of cells.
// ----------------------------------------------------------------------------
// The block takes one word (join or leave) in every clock cycle: busy stays
// low, so start alone decides acceptance. The result of a word appears on the
// o_ ports with o_done high in the cycle after it was accepted, for that one
// cycle only; the receiver cannot stall it and must capture it then. All
// DEPTH cells of the row update at the same edge: each cell compares the
// incoming priority against its own and either holds, shifts right to open
// a gap, or shifts left on a removal. The row is kept sorted by priority with
// older words ahead of equal ones, so the minimum is always in cell 0.
// Occupancy is a fill count; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned TAG_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_func,
    input  logic [smpq_pkg::OUT_TAG_BITS-1:0]     i_item_tag,
    input  logic signed [smpq_pkg::PRI_BITS-1:0]  i_item_priority,
    output logic                                  o_done,
    output logic [smpq_pkg::OUT_TAG_BITS-1:0]     o_removed_tag,
    output logic                                  o_removed_valid,
    output logic [smpq_pkg::OUT_TAG_BITS-1:0]     o_head_tag,
    output logic                                  o_queue_empty,
    output logic [1:0]                            o_status
);
    import smpq_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    // --- fill count ---------------------------------------------------------
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                accept;
    logic                is_full, is_empty;

    assign busy     = 1'b0;   // a word every cycle
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_BITS'(DEPTH));
    assign is_empty = (r_count == '0);

    // --- tag width conversion: stored at TAG_BITS, reported as low 16 ------
    logic [63:0]         in_tag_wide;
    logic [TAG_BITS-1:0] new_tag;
    assign in_tag_wide = 64'(i_item_tag);
    assign new_tag     = in_tag_wide[TAG_BITS-1:0];

    // --- cell control ------------------------------------------------------
    t_cell_ctl ctl;
    always_comb begin
        ctl.shift_in  = accept && (i_func == FUNC_JOIN)  && !is_full;
        ctl.shift_out = accept && (i_func == FUNC_LEAVE) && !is_empty;
    end

    // --- the row -----------------------------------------------------------
    logic [TAG_BITS-1:0]        c_tag    [DEPTH];
    logic signed [PRI_BITS-1:0] c_pri    [DEPTH];
    logic                       c_before [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                       prev_before;
        logic [TAG_BITS-1:0]        prev_tag, next_tag;
        logic signed [PRI_BITS-1:0] prev_pri, next_pri;

        if (g == 0) begin : g_first
            // nothing ahead of cell 0: when it opens a gap it takes the new word itself
            assign prev_before = 1'b0;
            assign prev_tag    = new_tag;
            assign prev_pri    = i_item_priority;
        end else begin : g_mid
            assign prev_before = c_before[g-1];
            assign prev_tag    = c_tag[g-1];
            assign prev_pri    = c_pri[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            // freed slot at the tail; its content is dead
            assign next_tag = c_tag[g];
            assign next_pri = c_pri[g];
        end else begin : g_inner
            assign next_tag = c_tag[g+1];
            assign next_pri = c_pri[g+1];
        end

        smpq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_valid       (CNT_BITS'(g) < r_count),
            .i_new_tag     (new_tag),
            .i_new_pri     (i_item_priority),
            .i_prev_before (prev_before),
            .i_prev_tag    (prev_tag),
            .i_prev_pri    (prev_pri),
            .i_next_tag    (next_tag),
            .i_next_pri    (next_pri),
            .o_tag         (c_tag[g]),
            .o_pri         (c_pri[g]),
            .o_before      (c_before[g])
        );
    end

    // --- result, worked out from the row before it moves ------------------
    logic [TAG_BITS-1:0] n_removed_tag_w, n_head_tag_w;
    logic [63:0]         removed_wide, head_wide;
    logic [1:0]          n_status;
    logic                n_removed_valid;

    always_comb begin
        n_count         = r_count;
        n_status        = STATUS_OK;
        n_removed_valid = 1'b0;
        n_removed_tag_w = '0;
        n_head_tag_w    = is_empty ? '0 : c_tag[0];
        if (i_func == FUNC_JOIN) begin
            if (is_full) begin
                n_status = STATUS_OVERFLOW;
            end else begin
                n_count = r_count + CNT_BITS'(1);
                // cell 0 flags before when empty or beaten by the new word
                n_head_tag_w = c_before[0] ? new_tag : c_tag[0];
            end
        end else begin
            if (is_empty) begin
                n_status = STATUS_UNDERFLOW;
            end else begin
                n_count         = r_count - CNT_BITS'(1);
                n_removed_valid = 1'b1;
                n_removed_tag_w = c_tag[0];
                n_head_tag_w    = (r_count > CNT_BITS'(1)) ? c_tag[1] : '0;
            end
        end
    end

    assign removed_wide = 64'(n_removed_tag_w);
    assign head_wide    = 64'(n_head_tag_w);

    // --- output register ---------------------------------------------------
    logic                    r_done;
    logic [OUT_TAG_BITS-1:0] r_removed_tag, r_head_tag;
    logic                    r_removed_valid, r_queue_empty;
    logic [1:0]              r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed_tag   <= removed_wide[OUT_TAG_BITS-1:0];
            r_removed_valid <= n_removed_valid;
            r_head_tag      <= head_wide[OUT_TAG_BITS-1:0];
            r_queue_empty   <= (n_count == '0);
            r_status        <= n_status;
        end
    end

    assign o_done          = r_done;
    assign o_removed_tag   = r_removed_tag;
    assign o_removed_valid = r_removed_valid;
    assign o_head_tag      = r_head_tag;
    assign o_queue_empty   = r_queue_empty;
    assign o_status        = r_status;

endmodule

// ===== hw/rtl/smpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the stable min-priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module smpq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  i_func,
    input logic [smpq_pkg::OUT_TAG_BITS-1:0]     i_item_tag,
    input logic signed [smpq_pkg::PRI_BITS-1:0]  i_item_priority,
    input logic                                  o_done,
    input logic [smpq_pkg::OUT_TAG_BITS-1:0]     o_removed_tag,
    input logic                                  o_removed_valid,
    input logic [smpq_pkg::OUT_TAG_BITS-1:0]     o_head_tag,
    input logic                                  o_queue_empty,
    input logic [1:0]                            o_status
);
    import smpq_pkg::*;

    // every accepted word gives its result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(start && !busy)) |=> !o_done)
        else $error("result without an accepted word");

    // a removal is always a clean leave
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_removed_valid) |-> (o_status == STATUS_OK))
        else $error("removal reported with bad status");

    // underflow leaves the queue empty and removes nothing
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STATUS_UNDERFLOW)
            |-> (o_queue_empty && !o_removed_valid && o_head_tag == '0))
        else $error("underflow result inconsistent");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_removed_valid) |-> (o_removed_tag == '0))
        else $error("removed tag not zero without removal");

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);

// ===== bench/smpq_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_monitor
// Watches the word and result channels of the stable min-priority queue,
// keeps its own copy of the queue contents in arrival order, predicts each
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module smpq_monitor #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic                                  i_func,
    input  logic [smpq_pkg::OUT_TAG_BITS-1:0]     i_item_tag,
    input  logic [smpq_pkg::PRI_BITS-1:0]         i_item_priority,
    input  logic                                  i_done,
    input  logic [smpq_pkg::OUT_TAG_BITS-1:0]     i_removed_tag,
    input  logic                                  i_removed_valid,
    input  logic [smpq_pkg::OUT_TAG_BITS-1:0]     i_head_tag,
    input  logic                                  i_queue_empty,
    input  logic [1:0]                            i_status,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_underflows,
    output int                                    o_overflows
);
    import smpq_pkg::*;

    typedef struct packed {
        logic [OUT_TAG_BITS-1:0] tag;
        logic [PRI_BITS-1:0]     pri;
    } t_entry;

    typedef struct packed {
        logic [OUT_TAG_BITS-1:0] removed_tag;
        logic                    removed_valid;
        logic [OUT_TAG_BITS-1:0] head_tag;
        logic                    queue_empty;
        logic [1:0]              status;
    } t_outcome;

    t_entry   queued_entries[$];   // live entries, oldest first
    t_outcome awaited_outcomes[$];
    t_outcome want;
    t_outcome got;
    int       failures;
    int       checked;
    int       underflows;
    int       overflows;

    task automatic report_mismatch(input string msg);
        failures++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // oldest entry among those holding the smallest priority
    function automatic int oldest_min_pos();
        int best;
        best = 0;
        for (int k = 1; k < queued_entries.size(); k++)
            if ($signed(queued_entries[k].pri) < $signed(queued_entries[best].pri))
                best = k;
        return best;
    endfunction

    function automatic t_outcome apply_word(input logic func,
                                            input logic [OUT_TAG_BITS-1:0] tag,
                                            input logic [PRI_BITS-1:0] pri);
        t_outcome res;
        t_entry   ent;
        int       pos;
        res = '0;
        if (func == FUNC_JOIN) begin
            if (queued_entries.size() >= DEPTH) begin
                res.status = STATUS_OVERFLOW;
            end else begin
                ent.tag = tag;
                ent.pri = pri;
                queued_entries.push_back(ent);
            end
        end else begin
            if (queued_entries.size() == 0) begin
                res.status = STATUS_UNDERFLOW;
            end else begin
                pos = oldest_min_pos();
                res.removed_tag   = queued_entries[pos].tag;
                res.removed_valid = 1'b1;
                queued_entries.delete(pos);
            end
        end
        if (queued_entries.size() > 0)
            res.head_tag = queued_entries[oldest_min_pos()].tag;
        res.queue_empty = (queued_entries.size() == 0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queued_entries.delete();
            awaited_outcomes.delete();
            failures   = 0;
            checked    = 0;
            underflows = 0;
            overflows  = 0;
        end else begin
            if (i_done) begin
                got = '{i_removed_tag, i_removed_valid, i_head_tag, i_queue_empty, i_status};
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result with no word outstanding");
                end else begin
                    want = awaited_outcomes.pop_front();
                    checked++;
                    if (want.status == STATUS_UNDERFLOW) underflows++;
                    if (want.status == STATUS_OVERFLOW)  overflows++;
                    if (got.removed_tag !== want.removed_tag)
                        report_mismatch($sformatf("removed_tag %h, want %h",
                                                  got.removed_tag, want.removed_tag));
                    if (got.removed_valid !== want.removed_valid)
                        report_mismatch($sformatf("removed_valid %b, want %b",
                                                  got.removed_valid, want.removed_valid));
                    if (got.head_tag !== want.head_tag)
                        report_mismatch($sformatf("head_tag %h, want %h",
                                                  got.head_tag, want.head_tag));
                    if (got.queue_empty !== want.queue_empty)
                        report_mismatch($sformatf("queue_empty %b, want %b",
                                                  got.queue_empty, want.queue_empty));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                end
            end
            if (i_start && !i_busy)
                awaited_outcomes.push_back(apply_word(i_func, i_item_tag, i_item_priority));
        end
        o_fail_count <= failures;
        o_pending    <= awaited_outcomes.size();
        o_checked    <= checked;
        o_underflows <= underflows;
        o_overflows  <= overflows;
    end

endmodule

// ===== bench/stable_min_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_tb
// Drives join and leave words into the stable min-priority queue and lets
// smpq_monitor predict and check every result; gives the verdict at the end.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_tb;
    import smpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 850;
    localparam int DRAIN_LIMIT  = 1000;   // cycles allowed for the last results
    localparam int TAIL_CYCLES  = 4;      // margin to catch any stray result

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_func = FUNC_JOIN;
    logic [OUT_TAG_BITS-1:0] i_item_tag = '0;
    logic [PRI_BITS-1:0]     i_item_priority = '0;
    logic                    o_done;
    logic [OUT_TAG_BITS-1:0] o_removed_tag;
    logic                    o_removed_valid;
    logic [OUT_TAG_BITS-1:0] o_head_tag;
    logic                    o_queue_empty;
    logic [1:0]              o_status;

    int fail_count;
    int pending;
    int checked;
    int underflows;
    int overflows;

    // stimulus bookkeeping, for the summary only
    int  joins_sent;
    int  leaves_sent;
    bit  gaps_on;

    stable_min_priority_queue #(
        .DEPTH    (DEPTH),
        .TAG_BITS (OUT_TAG_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_item_tag      (i_item_tag),
        .i_item_priority (i_item_priority),
        .o_done          (o_done),
        .o_removed_tag   (o_removed_tag),
        .o_removed_valid (o_removed_valid),
        .o_head_tag      (o_head_tag),
        .o_queue_empty   (o_queue_empty),
        .o_status        (o_status)
    );

    smpq_monitor #(
        .DEPTH (DEPTH)
    ) u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_item_tag      (i_item_tag),
        .i_item_priority (i_item_priority),
        .i_done          (o_done),
        .i_removed_tag   (o_removed_tag),
        .i_removed_valid (o_removed_valid),
        .i_head_tag      (o_head_tag),
        .i_queue_empty   (o_queue_empty),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_underflows    (underflows),
        .o_overflows     (overflows)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop, far beyond any correct run
    initial begin
        #200000;
        $display("Verification failed");
        $finish;
    end

    // Present one word and hold it until the handshake edge. Random gaps are
    // inserted first; start is only ever given one new value per edge, so a
    // back-to-back word keeps start high without a glitch.
    task automatic send_word(input logic func,
                             input logic [OUT_TAG_BITS-1:0] tag,
                             input logic [PRI_BITS-1:0] pri);
        while (gaps_on && $urandom_range(99) < 24) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= func;
        i_item_tag      <= tag;
        i_item_priority <= pri;
        do @(posedge i_clk); while (busy);
        if (func == FUNC_JOIN) joins_sent++;
        else                   leaves_sent++;
    endtask

    // Priorities lean towards a small pool so that ties are common; the rest
    // are the extremes of the signed range, -1, zero or fully random words.
    function automatic logic [PRI_BITS-1:0] pick_priority();
        logic [PRI_BITS-1:0] pri;
        case ($urandom_range(9))
            0, 1, 2, 3: pri = (int'($urandom_range(6)) - 3) * 32'sh0001_0000;
            4:          pri = 32'h0000_8000 * $urandom_range(3);
            5: begin
                case ($urandom_range(3))
                    0:       pri = 32'h8000_0000;
                    1:       pri = 32'h7FFF_FFFF;
                    2:       pri = 32'hFFFF_FFFF;
                    default: pri = 32'h0000_0000;
                endcase
            end
            default:    pri = $urandom;
        endcase
        return pri;
    endfunction

    initial begin
        logic [PRI_BITS-1:0] tie_pool [3];
        int                  join_bias;
        int                  burst_len;
        int                  sent;
        int                  waited;

        tie_pool[0] = 32'h8000_0000;
        tie_pool[1] = 32'h7FFF_FFFF;
        tie_pool[2] = 32'h0000_0000;
        joins_sent  = 0;
        leaves_sent = 0;
        gaps_on     = 1'b1;

        // synchronous reset, held low and then released
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // leave on an empty queue: underflow, junk in the ignored fields
        send_word(FUNC_LEAVE, 16'hFFFF, 32'hFFFF_FFFF);
        // extremes of tag and priority
        send_word(FUNC_JOIN, 16'h0000, 32'h7FFF_FFFF);
        send_word(FUNC_JOIN, 16'hFFFF, 32'h8000_0000);
        send_word(FUNC_JOIN, 16'h0001, 32'h0000_0000);
        // four equal priorities: arrival order must decide
        for (int i = 0; i < 4; i++)
            send_word(FUNC_JOIN, 16'(16'h0A01 + i), 32'h0001_8000);
        send_word(FUNC_JOIN, 16'h0B00, 32'hFFFF_FFFF);
        // fill to one short of the top, tying with the minimum, the maximum and zero
        for (int i = 0; i < 7; i++)
            send_word(FUNC_JOIN, 16'(16'h0C00 + i), tie_pool[i % 3]);
        // the last free slot: this join fills the queue
        send_word(FUNC_JOIN, 16'h5A5A, 32'h8000_0000);
        // drain the most negative ties, oldest first
        send_word(FUNC_LEAVE, 16'h0000, 32'h0000_0000);
        send_word(FUNC_LEAVE, 16'hAAAA, 32'h5555_5555);
        send_word(FUNC_LEAVE, 16'h5555, 32'hAAAA_AAAA);
        send_word(FUNC_LEAVE, 16'h0000, 32'h0000_0000);

        // --- random part ---
        // Bursts with a join bias, so the queue swings between full and
        // empty often; a stretch in the middle runs with no gaps at all.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(2))
                0:       join_bias = 15;
                1:       join_bias = 50;
                default: join_bias = 85;
            endcase
            burst_len = $urandom_range(10, 60);
            for (int b = 0; b < burst_len && sent < RANDOM_WORDS; b++) begin
                gaps_on = !(sent >= 300 && sent < 460);
                if ($urandom_range(99) < join_bias)
                    send_word(FUNC_JOIN, 16'($urandom), pick_priority());
                else
                    send_word(FUNC_LEAVE, 16'($urandom), $urandom);
                sent++;
            end
        end
        start <= 1'b0;

        // wait for the last results, with a limit
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0) begin
            $display("Verification failed");
            $finish;
        end else begin
            // wait on, to catch any stray result
            repeat (TAIL_CYCLES) @(posedge i_clk);
            $display("Covered %0d words (%0d joins, %0d leaves), %0d results checked,",
                     joins_sent + leaves_sent, joins_sent, leaves_sent, checked);
            $display("with %0d underflows, %0d overflows, priority ties and extremes.",
                     underflows, overflows);
            if (fail_count == 0) begin
                $display("Verification passed");
            end else begin
                $display("Verification failed");
            end
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/stable_min_priority_queue.sv
hw/rtl/smpq_checker.sv
bench/smpq_monitor.sv
bench/stable_min_priority_queue_tb.sv
